/* sv/dls_pkg.sv */
// Shared types, codes and defaults for the dense layer training engine.
package dls_pkg;

    localparam int DEF_MAX_IN    = 16;
    localparam int DEF_MAX_OUT   = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CNT_W  = 5;
    localparam int STEP_W = 17;
    localparam int CFG_W  = 17;

    localparam logic [STEP_W-1:0] STEP_RST = 17'd655;
    localparam logic [CNT_W-1:0]  COUNT_RST = 5'd16;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 5'd31;

    // item commands
    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_FWD    = 2'd2;
    localparam logic [1:0] CMD_BWD    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_IN   = 2'd1;
    localparam logic [1:0] CFG_OUT  = 2'd2;

    // multiplier operand selection
    localparam logic [2:0] MUL_VS = 3'd0;  // value * slope
    localparam logic [2:0] MUL_WB = 3'd1;  // weight * input or gradient
    localparam logic [2:0] MUL_GX = 3'd2;  // gradient * input
    localparam logic [2:0] MUL_LG = 3'd3;  // rate * weight gradient
    localparam logic [2:0] MUL_LB = 3'd4;  // rate * gradient

    typedef struct packed {
        logic       cap;
        logic       mem_rd;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       gw_en;
        logic       acc_init;
        logic       acc_add;
        logic       res_load;
        logic       w_we_load;
        logic       b_we_load;
        logic       x_we;
        logic       g_we;
        logic       w_we_upd;
        logic       b_we_upd;
        logic       bwd;
        logic       res_kind;
        logic [3:0] res_index;
        logic       res_end;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       last;
        logic       w_ok;
        logic       b_ok;
    } t_dp_stat;

endpackage

/* sv/dls_datapath.sv */
// Datapath: stores, shared multiplier, accumulator and result register.
module dls_datapath #(
    parameter int MAX_IN    = dls_pkg::DEF_MAX_IN,
    parameter int MAX_OUT   = dls_pkg::DEF_MAX_OUT,
    parameter int FRAC_BITS = dls_pkg::DEF_FRAC_BITS,
    localparam int RW   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1,
    localparam int CW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
    localparam int WA_W = (MAX_OUT * MAX_IN > 1) ? $clog2(MAX_OUT * MAX_IN) : 1,
    localparam int MAXN = (MAX_IN > MAX_OUT) ? MAX_IN : MAX_OUT
) (
    input  logic                             i_clk,
    input  dls_pkg::t_dp_cmd                 i_cmd,
    input  logic [RW-1:0]                    i_row,
    input  logic [CW-1:0]                    i_col,
    input  logic [dls_pkg::CNT_W-1:0]        i_elem,
    input  logic [dls_pkg::STEP_W-1:0]       i_step_size,
    input  logic [1:0]                       i_command,
    input  logic [3:0]                       i_item_row,
    input  logic [3:0]                       i_item_col,
    input  logic signed [31:0]               i_value,
    input  logic signed [31:0]               i_slope,
    input  logic                             i_last,
    output dls_pkg::t_dp_stat                o_stat,
    output logic                             o_kind,
    output logic [3:0]                       o_index,
    output logic signed [31:0]               o_result_value,
    output logic                             o_end_of_run
);

    localparam int ACC_W = 64 + $clog2(MAXN + 1) + 1;
    localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SMAX)      r = 32'sh7fffffff;
        else if (v < SMIN) r = 32'sh80000000;
        else               r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) r = d[32] ? 32'sh80000000 : 32'sh7fffffff;
        else                r = d[31:0];
        return r;
    endfunction

    logic signed [31:0] mem_w [MAX_OUT*MAX_IN];
    logic signed [31:0] mem_b [MAX_OUT];
    logic signed [31:0] mem_x [MAX_IN];
    logic signed [31:0] mem_g [MAX_OUT];

    logic [1:0]         r_c_cmd;
    logic [3:0]         r_c_row;
    logic [3:0]         r_c_col;
    logic signed [31:0] r_c_value;
    logic signed [31:0] r_c_slope;
    logic               r_c_last;

    logic signed [31:0]      r_w_q, r_b_q, r_x_q, r_g_q;
    logic signed [63:0]      r_prod;
    logic signed [31:0]      r_gw;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_res;
    logic                    r_kind, r_end;
    logic [3:0]              r_index;

    logic signed [31:0]      mul_a, mul_b, lr;
    logic signed [63:0]      prod_sh;
    logic signed [ACC_W-1:0] term, acc_sum;
    logic signed [31:0]      prod_sat;
    logic [WA_W-1:0]         rd_addr, ld_addr, w_addr;
    logic                    w_we, b_we;
    logic signed [31:0]      w_wdata, b_wdata;
    logic [RW-1:0]           b_addr;

    assign lr       = {{(32-dls_pkg::STEP_W){1'b0}}, i_step_size};
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign term     = {{(ACC_W-64){prod_sh[63]}}, prod_sh};
    assign prod_sat = sat32(term);
    assign acc_sum  = r_acc + term;

    always_comb begin
        case (i_cmd.mul_sel)
            dls_pkg::MUL_VS: begin
                mul_a = r_c_value;
                mul_b = r_c_slope;
            end
            dls_pkg::MUL_WB: begin
                mul_a = r_w_q;
                mul_b = i_cmd.bwd ? r_g_q : r_x_q;
            end
            dls_pkg::MUL_GX: begin
                mul_a = r_g_q;
                mul_b = r_x_q;
            end
            dls_pkg::MUL_LG: begin
                mul_a = lr;
                mul_b = r_gw;
            end
            default: begin
                mul_a = lr;
                mul_b = r_g_q;
            end
        endcase
    end

    assign rd_addr = WA_W'(32'(i_row) * MAX_IN + 32'(i_col));
    assign ld_addr = WA_W'(32'(r_c_row) * MAX_IN + 32'(r_c_col));
    assign w_we    = i_cmd.w_we_load | i_cmd.w_we_upd;
    assign w_addr  = i_cmd.w_we_load ? ld_addr : rd_addr;
    assign w_wdata = i_cmd.w_we_load ? r_c_value : sat_sub(r_w_q, prod_sat);
    assign b_we    = i_cmd.b_we_load | i_cmd.b_we_upd;
    assign b_addr  = i_cmd.b_we_load ? RW'(r_c_row) : i_row;
    assign b_wdata = i_cmd.b_we_load ? r_c_value : sat_sub(r_b_q, prod_sat);

    always_ff @(posedge i_clk) begin
        if (w_we) mem_w[w_addr] <= w_wdata;
        if (i_cmd.mem_rd) r_w_q <= mem_w[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) mem_b[b_addr] <= b_wdata;
        if (i_cmd.mem_rd) r_b_q <= mem_b[i_row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_we) mem_x[CW'(i_elem)] <= r_c_value;
        if (i_cmd.mem_rd) r_x_q <= mem_x[i_col];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.g_we) mem_g[RW'(i_elem)] <= prod_sat;
        if (i_cmd.mem_rd) r_g_q <= mem_g[i_row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_c_cmd   <= i_command;
            r_c_row   <= i_item_row;
            r_c_col   <= i_item_col;
            r_c_value <= i_value;
            r_c_slope <= i_slope;
            r_c_last  <= i_last;
        end
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.gw_en)  r_gw <= prod_sat;
        if (i_cmd.acc_init) begin
            r_acc <= i_cmd.bwd ? '0 : {{(ACC_W-32){r_b_q[31]}}, r_b_q};
        end else if (i_cmd.acc_add) begin
            r_acc <= acc_sum;
        end
        if (i_cmd.res_load) begin
            r_res   <= sat32(acc_sum);
            r_kind  <= i_cmd.res_kind;
            r_index <= i_cmd.res_index;
            r_end   <= i_cmd.res_end;
        end
    end

    assign o_stat.cmd  = r_c_cmd;
    assign o_stat.last = r_c_last;
    assign o_stat.w_ok = (32'(r_c_row) < MAX_OUT) && (32'(r_c_col) < MAX_IN);
    assign o_stat.b_ok = (32'(r_c_row) < MAX_OUT);

    assign o_kind         = r_kind;
    assign o_index        = r_index;
    assign o_result_value = r_res;
    assign o_end_of_run   = r_end;

endmodule

/* sv/dls_ctrl.sv */
// Controller: configuration registers, element counter and sequencing FSM.
module dls_ctrl #(
    parameter int MAX_IN  = dls_pkg::DEF_MAX_IN,
    parameter int MAX_OUT = dls_pkg::DEF_MAX_OUT,
    localparam int RW   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1,
    localparam int CW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
    localparam int MAXN = (MAX_IN > MAX_OUT) ? MAX_IN : MAX_OUT,
    localparam int LW   = (MAXN > 1) ? $clog2(MAXN) : 1,
    localparam int NW   = LW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dls_pkg::CFG_W-1:0]     i_cfg_data,
    input  dls_pkg::t_dp_stat             i_stat,
    output dls_pkg::t_dp_cmd              o_cmd,
    output logic [RW-1:0]                 o_row,
    output logic [CW-1:0]                 o_col,
    output logic [dls_pkg::CNT_W-1:0]     o_elem,
    output logic [dls_pkg::STEP_W-1:0]    o_step_size
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_GSTORE = 4'd2;
    localparam logic [3:0] S_M_RD   = 4'd3;
    localparam logic [3:0] S_M_MUL  = 4'd4;
    localparam logic [3:0] S_M_ACC  = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;
    localparam logic [3:0] S_U_RD   = 4'd7;
    localparam logic [3:0] S_U_MUL1 = 4'd8;
    localparam logic [3:0] S_U_SAT  = 4'd9;
    localparam logic [3:0] S_U_MUL2 = 4'd10;
    localparam logic [3:0] S_U_WR   = 4'd11;
    localparam logic [3:0] S_B_RD   = 4'd12;
    localparam logic [3:0] S_B_MUL  = 4'd13;
    localparam logic [3:0] S_B_WR   = 4'd14;

    logic [3:0]                    r_state, n_state;
    logic [dls_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [LW-1:0]                 r_outer, n_outer, r_inner, n_inner;
    logic                          r_bwd, n_bwd;
    logic [dls_pkg::STEP_W-1:0]    r_step, n_step;
    logic [dls_pkg::CNT_W-1:0]     r_in_count, n_in_count, r_out_count, n_out_count;

    logic [NW-1:0] ni, no, m_ilim, m_olim;
    logic          m_in_last, m_out_last, u_in_last, u_out_last, m_phase;
    logic [dls_pkg::CNT_W-1:0] cnt_step;

    assign ni = (r_in_count == '0) ? NW'(1) :
                (32'(r_in_count) > MAX_IN) ? NW'(MAX_IN) : NW'(r_in_count);
    assign no = (r_out_count == '0) ? NW'(1) :
                (32'(r_out_count) > MAX_OUT) ? NW'(MAX_OUT) : NW'(r_out_count);

    // matrix pass: forward walks rows outer, backward walks columns outer
    assign m_ilim     = r_bwd ? no : ni;
    assign m_olim     = r_bwd ? ni : no;
    assign m_in_last  = ({1'b0, r_inner} == m_ilim - NW'(1));
    assign m_out_last = ({1'b0, r_outer} == m_olim - NW'(1));
    assign u_in_last  = ({1'b0, r_inner} == ni - NW'(1));
    assign u_out_last = ({1'b0, r_outer} == no - NW'(1));

    assign m_phase = (r_state == S_M_RD) || (r_state == S_M_MUL) ||
                     (r_state == S_M_ACC) || (r_state == S_OUT);
    assign o_row   = (m_phase && r_bwd) ? RW'(r_inner) : RW'(r_outer);
    assign o_col   = (m_phase && r_bwd) ? CW'(r_outer) : CW'(r_inner);

    assign cnt_step = i_stat.last ? '0 :
                      (r_cnt < dls_pkg::CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    assign o_elem      = r_cnt;
    assign o_step_size = r_step;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);

    always_comb begin
        n_step      = r_step;
        n_in_count  = r_in_count;
        n_out_count = r_out_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                dls_pkg::CFG_STEP: n_step      = i_cfg_data[dls_pkg::STEP_W-1:0];
                dls_pkg::CFG_IN:   n_in_count  = i_cfg_data[dls_pkg::CNT_W-1:0];
                dls_pkg::CFG_OUT:  n_out_count = i_cfg_data[dls_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_outer = r_outer;
        n_inner = r_inner;
        n_bwd   = r_bwd;
        o_cmd   = '0;
        o_cmd.bwd       = r_bwd;
        o_cmd.res_kind  = r_bwd;
        o_cmd.res_index = 4'(r_outer);
        o_cmd.res_end   = m_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    dls_pkg::CMD_WEIGHT: begin
                        o_cmd.w_we_load = i_stat.w_ok;
                        n_state = S_IDLE;
                    end
                    dls_pkg::CMD_BIAS: begin
                        o_cmd.b_we_load = i_stat.b_ok;
                        n_state = S_IDLE;
                    end
                    dls_pkg::CMD_FWD: begin
                        o_cmd.x_we = (r_cnt < ni);
                        n_cnt = cnt_step;
                        if (i_stat.last) begin
                            n_bwd   = 1'b0;
                            n_outer = '0;
                            n_inner = '0;
                            n_state = S_M_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = dls_pkg::MUL_VS;
                        n_state = S_GSTORE;
                    end
                endcase
            end
            S_GSTORE: begin
                o_cmd.g_we = (r_cnt < no);
                n_cnt = cnt_step;
                if (i_stat.last) begin
                    n_bwd   = 1'b1;
                    n_outer = '0;
                    n_inner = '0;
                    n_state = S_M_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_M_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_M_MUL;
            end
            S_M_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = dls_pkg::MUL_WB;
                o_cmd.acc_init = (r_inner == '0);
                n_state = S_M_ACC;
            end
            S_M_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (m_in_last) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_inner = r_inner + 1'b1;
                    n_state = S_M_RD;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_inner = '0;
                    if (m_out_last) begin
                        n_outer = '0;
                        n_state = r_bwd ? S_U_RD : S_IDLE;
                    end else begin
                        n_outer = r_outer + 1'b1;
                        n_state = S_M_RD;
                    end
                end
            end
            S_U_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_U_MUL1;
            end
            S_U_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = dls_pkg::MUL_GX;
                n_state = S_U_SAT;
            end
            S_U_SAT: begin
                o_cmd.gw_en = 1'b1;
                n_state = S_U_MUL2;
            end
            S_U_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = dls_pkg::MUL_LG;
                n_state = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.w_we_upd = 1'b1;
                if (u_in_last) begin
                    n_state = S_B_RD;
                end else begin
                    n_inner = r_inner + 1'b1;
                    n_state = S_U_RD;
                end
            end
            S_B_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_B_MUL;
            end
            S_B_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = dls_pkg::MUL_LB;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.b_we_upd = 1'b1;
                n_inner = '0;
                if (u_out_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_outer = r_outer + 1'b1;
                    n_state = S_U_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_outer     <= '0;
            r_inner     <= '0;
            r_bwd       <= 1'b0;
            r_step      <= dls_pkg::STEP_RST;
            r_in_count  <= dls_pkg::COUNT_RST;
            r_out_count <= dls_pkg::COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_outer     <= n_outer;
            r_inner     <= n_inner;
            r_bwd       <= n_bwd;
            r_step      <= n_step;
            r_in_count  <= n_in_count;
            r_out_count <= n_out_count;
        end
    end

endmodule

/* sv/dense_layer_sgd_engine_unit.sv */
// Top level of the dense layer training engine: controller plus datapath.
// One item is taken at a time. Weight and bias writes and forward elements
// pass through the execute state, backward elements also through a gradient
// store state. A forward item marked last then runs in_count * out_count
// multiply-accumulates, each in read, multiply and accumulate steps, and each
// of the out_count results waits in the output register until taken. A
// backward item marked last runs the same steps for the in_count input
// gradients, then updates each weight in read, multiply, saturate, multiply
// and write steps and each bias in read, multiply and write steps, all on the
// single shared 32x32 multiplier with registered memory reads. Counts of zero
// act as one; counts above the store size act as the store size.
module dense_layer_sgd_engine_unit #(
    parameter int MAX_IN    = dls_pkg::DEF_MAX_IN,
    parameter int MAX_OUT   = dls_pkg::DEF_MAX_OUT,
    parameter int FRAC_BITS = dls_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_command,
    input  logic [3:0]                 i_row,
    input  logic [3:0]                 i_col,
    input  logic signed [31:0]         i_value,
    input  logic signed [31:0]         i_slope,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_kind,
    output logic [3:0]                 o_index,
    output logic signed [31:0]         o_result_value,
    output logic                       o_end_of_run,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [dls_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int RW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int CW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    dls_pkg::t_dp_cmd             cmd;
    dls_pkg::t_dp_stat            stat;
    logic [RW-1:0]                row;
    logic [CW-1:0]                col;
    logic [dls_pkg::CNT_W-1:0]    elem;
    logic [dls_pkg::STEP_W-1:0]   step_size;

    dls_ctrl #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_row       (row),
        .o_col       (col),
        .o_elem      (elem),
        .o_step_size (step_size)
    );

    dls_datapath #(
        .MAX_IN    (MAX_IN),
        .MAX_OUT   (MAX_OUT),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_row          (row),
        .i_col          (col),
        .i_elem         (elem),
        .i_step_size    (step_size),
        .i_command      (i_command),
        .i_item_row     (i_row),
        .i_item_col     (i_col),
        .i_value        (i_value),
        .i_slope        (i_slope),
        .i_last         (i_last),
        .o_stat         (stat),
        .o_kind         (o_kind),
        .o_index        (o_index),
        .o_result_value (o_result_value),
        .o_end_of_run   (o_end_of_run)
    );

endmodule
